### sv/tal_pkg.sv
// ----------------------------------------------------------------------------
// tal_pkg
// Shared constants and the table address function for the binary-lifting ancestor engine.
// ----------------------------------------------------------------------------
package tal_pkg;

    localparam int NODES      = 256;
    localparam int LEVELS     = 9;
    localparam int NODE_W     = $clog2(NODES);
    localparam int LEVEL_W    = $clog2(LEVELS);
    localparam int EDGE_CAP   = NODES - 1;
    localparam int ANC_DEPTH  = NODES * LEVELS;
    localparam int ANC_AW     = $clog2(ANC_DEPTH);
    localparam int ANC_W      = NODE_W + 1;
    localparam int DEPTH_W    = NODE_W;

    localparam logic [2:0] CMD_ADD   = 3'd0;
    localparam logic [2:0] CMD_BUILD = 3'd1;
    localparam logic [2:0] CMD_KTH   = 3'd2;
    localparam logic [2:0] CMD_LCA   = 3'd3;
    localparam logic [2:0] CMD_CLEAR = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam logic [ANC_W-1:0] NONE = ANC_W'(NODES);

    localparam logic [1:0] REG_NODE_COUNT = 2'd0;
    localparam logic [1:0] REG_ROOT_NODE  = 2'd1;

    // Flat ancestor table address: node-major, level-minor
    function automatic logic [ANC_AW-1:0] anc_addr(input logic [NODE_W-1:0] node,
                                                   input logic [LEVEL_W-1:0] lvl);
        anc_addr = ANC_AW'(node) * ANC_AW'(LEVELS) + ANC_AW'(lvl);
    endfunction

endpackage

### sv/tal_ram.sv
// ----------------------------------------------------------------------------
// tal_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module tal_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write, with a registered read that returns the old contents
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

### sv/tree_ancestor_lca_engine_top.sv
// ----------------------------------------------------------------------------
// tree_ancestor_lca_engine_top
// Binary-lifting tree engine: edge store, build, k-th ancestor and LCA.
// ----------------------------------------------------------------------------
// One word is taken at a time. Ready stays low until its result word has been
// taken. After reset a clearing pass sets every ancestor entry to none and
// every depth to zero, and ready stays low during it. Add edge, clear, unknown
// commands and out-of-range words go straight to the done state, which
// registers the result. A k-th ancestor query climbs by one table read per set
// distance bit. An LCA fetches both depths, climbs the deeper node by the depth
// difference, then, unless the two nodes meet, descends over all LEVELS levels
// from the top and ends with a read of the last parent. Build is paced by the
// single-port ancestor RAM: a clear pass, then repeated passes over the edge
// store, both directions of each edge, until no node changes, then for each of
// LEVELS-1 levels one step per node in use, with the write skipped when the
// node has no ancestor at that level. Reached marks sit in flip-flops; depths
// and edges in RAM.
// ----------------------------------------------------------------------------
module tree_ancestor_lca_engine_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_command,
    input  logic [7:0]  i_node_a,
    input  logic [7:0]  i_node_b,
    input  logic [7:0]  i_distance,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_result_node,
    output logic        o_result_valid,
    output logic [1:0]  o_status
);
    localparam int NW = tal_pkg::NODE_W;
    localparam int AW = tal_pkg::ANC_W;
    localparam int LW = tal_pkg::LEVEL_W;
    localparam int CW = tal_pkg::ANC_AW;

    typedef enum logic [4:0] {
        S_IDLE, S_CLR, S_PASS_RD, S_PASS_W1, S_PASS_EV, S_PASS_WR,
        S_FILL_RD, S_FILL_W1, S_FILL_RD2, S_FILL_W2, S_FILL_WR,
        S_CL_RD, S_CL_W, S_CL_NX,
        S_LC_DP, S_LC_DW, S_LC_DQ, S_LC_DQW,
        S_LC_RA, S_LC_WA, S_LC_RB, S_LC_WB, S_LC_CMP, S_LC_LAST, S_LC_LW,
        S_DONE
    } t_state;

    t_state r_state;

    // Configuration
    logic [8:0] r_node_count;
    logic [7:0] r_root;
    logic [8:0] eff_n;
    assign eff_n = (r_node_count > 9'(tal_pkg::NODES)) ? 9'(tal_pkg::NODES) : r_node_count;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= 9'd256;
            r_root       <= 8'd0;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == tal_pkg::REG_ROOT_NODE[0]) r_root <= pwdata[7:0];
            else r_node_count <= pwdata[8:0];
        end
    end

    always_comb begin
        if (paddr[2] == tal_pkg::REG_ROOT_NODE[0]) prdata = {24'd0, r_root};
        else prdata = {23'd0, r_node_count};
    end

    // Memories
    logic          anc_we;
    logic [tal_pkg::ANC_AW-1:0] anc_addr;
    logic [AW-1:0] anc_wd, anc_rd;
    tal_ram #(.WIDTH(AW), .DEPTH(tal_pkg::ANC_DEPTH)) u_anc (
        .i_clk(i_clk), .i_we(anc_we), .i_addr(anc_addr), .i_wdata(anc_wd), .o_rdata(anc_rd));

    logic          dep_we;
    logic [NW-1:0] dep_addr;
    logic [7:0]    dep_wd, dep_rd;
    tal_ram #(.WIDTH(8), .DEPTH(tal_pkg::NODES)) u_dep (
        .i_clk(i_clk), .i_we(dep_we), .i_addr(dep_addr), .i_wdata(dep_wd), .o_rdata(dep_rd));

    logic          edg_we;
    logic [7:0]    edg_addr;
    logic [15:0]   edg_wd, edg_rd;
    tal_ram #(.WIDTH(16), .DEPTH(tal_pkg::EDGE_CAP)) u_edg (
        .i_clk(i_clk), .i_we(edg_we), .i_addr(edg_addr), .i_wdata(edg_wd), .o_rdata(edg_rd));

    // Working registers
    logic [tal_pkg::NODES-1:0] r_mark;
    logic [7:0]    r_etot;
    logic [7:0]    r_eidx;
    logic          r_chg;
    logic          r_side;    // second direction of edge
    logic          r_init;    // clearing pass after reset
    logic [tal_pkg::ANC_AW-1:0] r_ca;
    logic [NW-1:0] r_x;       // node cursor / p
    logic [NW-1:0] r_q;
    logic [LW-1:0] r_lvl;
    logic [7:0]    r_k;
    logic [7:0]    r_dp;
    logic [AW-1:0] r_tmp;
    logic [AW-1:0] r_res;
    logic [1:0]    r_st;
    logic          r_lca;
    logic          r_valid;

    logic [NW-1:0] eu, ev;
    assign eu = edg_rd[15:8];
    assign ev = edg_rd[7:0];

    // Root as a one-hot mark vector
    logic [tal_pkg::NODES-1:0] root_mark;
    always_comb begin
        root_mark = '0;
        root_mark[r_root] = 1'b1;
    end

    // Lowest set bit position of the remaining climb distance
    logic [3:0] k_bit;
    always_comb begin
        k_bit = 4'd8;
        for (int i = 7; i >= 0; i--) begin
            if (r_k[i]) k_bit = 4'(i);
        end
    end

    // Memory port drive
    always_comb begin
        anc_we = 1'b0; anc_addr = r_ca; anc_wd = tal_pkg::NONE;
        dep_we = 1'b0; dep_addr = r_x; dep_wd = 8'd0;
        edg_we = 1'b0; edg_addr = r_eidx; edg_wd = {i_node_a, i_node_b};
        unique case (r_state)
            S_IDLE: begin
                edg_addr = r_etot;
                edg_we = i_valid && (i_command == tal_pkg::CMD_ADD) &&
                         (9'(i_node_a) < eff_n) && (9'(i_node_b) < eff_n) &&
                         (r_etot < 8'(tal_pkg::EDGE_CAP));
            end
            S_CLR: begin
                anc_we = 1'b1;
                dep_we = (r_lvl == '0);
            end
            S_PASS_RD, S_PASS_W1: ;
            S_PASS_EV: begin
                dep_addr = r_side ? ev : eu;
            end
            S_PASS_WR: begin
                anc_we = 1'b1;
                anc_addr = tal_pkg::anc_addr(r_side ? eu : ev, '0);
                anc_wd = AW'(r_side ? ev : eu);
                dep_we = 1'b1;
                dep_addr = r_side ? eu : ev;
                dep_wd = dep_rd + 8'd1;
            end
            S_FILL_RD, S_FILL_W1: anc_addr = tal_pkg::anc_addr(r_x, r_lvl);
            S_FILL_RD2, S_FILL_W2: anc_addr = tal_pkg::anc_addr(r_tmp[NW-1:0], r_lvl);
            S_FILL_WR: begin
                anc_we = 1'b1;
                anc_addr = tal_pkg::anc_addr(r_x, r_lvl + LW'(1));
                anc_wd = anc_rd;
            end
            S_CL_RD, S_CL_W, S_CL_NX: anc_addr = tal_pkg::anc_addr(r_x, k_bit[LW-1:0]);
            S_LC_DP, S_LC_DW: dep_addr = r_x;
            S_LC_DQ, S_LC_DQW: dep_addr = r_q;
            S_LC_RA, S_LC_WA, S_LC_LAST, S_LC_LW: anc_addr = tal_pkg::anc_addr(r_x, r_lvl);
            S_LC_RB, S_LC_WB, S_LC_CMP: anc_addr = tal_pkg::anc_addr(r_q, r_lvl);
            default: ;
        endcase
    end

    assign o_ready = (r_state == S_IDLE);

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_init  <= 1'b1;
            r_ca    <= '0;
            r_x     <= '0;
            r_lvl   <= '0;
            r_mark  <= '0;
            r_etot  <= '0;
            r_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_res <= tal_pkg::NONE;
                        r_q   <= i_node_b;
                        r_k   <= i_distance;
                        unique case (i_command)
                            tal_pkg::CMD_ADD: begin
                                r_x <= i_node_a;
                                r_state <= S_DONE;
                                if (9'(i_node_a) >= eff_n || 9'(i_node_b) >= eff_n)
                                    r_st <= tal_pkg::ST_RANGE;
                                else if (r_etot >= 8'(tal_pkg::EDGE_CAP))
                                    r_st <= tal_pkg::ST_FULL;
                                else begin
                                    r_st <= tal_pkg::ST_OK;
                                    r_etot <= r_etot + 8'd1;
                                end
                            end
                            tal_pkg::CMD_BUILD: begin
                                if (9'(r_root) >= eff_n) begin
                                    r_x <= i_node_a;
                                    r_st <= tal_pkg::ST_RANGE;
                                    r_state <= S_DONE;
                                end else begin
                                    r_st <= tal_pkg::ST_OK;
                                    r_ca <= '0; r_x <= '0; r_lvl <= '0;
                                    r_state <= S_CLR;
                                end
                            end
                            tal_pkg::CMD_KTH: begin
                                r_x <= i_node_a;
                                if (9'(i_node_a) >= eff_n) begin
                                    r_st <= tal_pkg::ST_RANGE;
                                    r_state <= S_DONE;
                                end else begin
                                    r_st <= tal_pkg::ST_OK;
                                    r_lca <= 1'b0;
                                    r_state <= S_CL_RD;
                                end
                            end
                            tal_pkg::CMD_LCA: begin
                                r_x <= i_node_a;
                                if (9'(i_node_a) >= eff_n || 9'(i_node_b) >= eff_n) begin
                                    r_st <= tal_pkg::ST_RANGE;
                                    r_state <= S_DONE;
                                end else begin
                                    r_st <= tal_pkg::ST_OK;
                                    r_state <= S_LC_DP;
                                end
                            end
                            tal_pkg::CMD_CLEAR: begin
                                r_x <= i_node_a;
                                r_st <= tal_pkg::ST_OK;
                                r_etot <= '0;
                                r_state <= S_DONE;
                            end
                            default: begin
                                r_x <= i_node_a;
                                r_st <= tal_pkg::ST_OK;
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                // Clear table and depths, one entry a cycle
                S_CLR: begin
                    r_ca <= r_ca + CW'(1);
                    if (r_lvl == LW'(tal_pkg::LEVELS - 1)) begin
                        r_lvl <= '0;
                        r_x <= r_x + NW'(1);
                    end else r_lvl <= r_lvl + LW'(1);
                    if (r_ca == CW'(tal_pkg::ANC_DEPTH - 1)) begin
                        if (r_init) begin
                            r_init <= 1'b0;
                            r_state <= S_IDLE;
                        end else begin
                            r_mark <= root_mark;
                            r_eidx <= '0; r_chg <= 1'b0; r_side <= 1'b0;
                            r_state <= S_PASS_RD;
                        end
                    end
                end
                // Link passes over the edge store
                S_PASS_RD: begin
                    if (r_eidx >= r_etot) begin
                        if (r_chg) begin
                            r_eidx <= '0; r_chg <= 1'b0;
                        end else begin
                            r_x <= '0; r_lvl <= '0;
                            r_state <= S_FILL_RD;
                        end
                    end else r_state <= S_PASS_W1;
                end
                S_PASS_W1: r_state <= S_PASS_EV;
                S_PASS_EV: begin
                    if (9'(eu) < eff_n && 9'(ev) < eff_n &&
                        (r_side ? (r_mark[ev] && !r_mark[eu]) : (r_mark[eu] && !r_mark[ev])))
                        r_state <= S_PASS_WR;
                    else if (r_side) begin
                        r_side <= 1'b0; r_eidx <= r_eidx + 8'd1; r_state <= S_PASS_RD;
                    end else r_side <= 1'b1;
                end
                S_PASS_WR: begin
                    r_chg <= 1'b1;
                    r_mark[r_side ? eu : ev] <= 1'b1;
                    if (r_side) begin
                        r_side <= 1'b0; r_eidx <= r_eidx + 8'd1; r_state <= S_PASS_RD;
                    end else begin
                        r_side <= 1'b1; r_state <= S_PASS_EV;
                    end
                end
                // Fill higher levels: table[x][i+1] = table[table[x][i]][i]
                S_FILL_RD: r_state <= S_FILL_W1;
                S_FILL_W1: begin
                    r_tmp <= anc_rd;
                    if (anc_rd[NW]) begin
                        // none: skip write
                        if (9'(r_x) + 9'd1 >= eff_n) begin
                            r_x <= '0;
                            if (r_lvl == LW'(tal_pkg::LEVELS - 2)) r_state <= S_DONE;
                            else begin r_lvl <= r_lvl + LW'(1); r_state <= S_FILL_RD; end
                        end else begin r_x <= r_x + NW'(1); r_state <= S_FILL_RD; end
                    end else r_state <= S_FILL_RD2;
                end
                S_FILL_RD2: r_state <= S_FILL_W2;
                S_FILL_W2: r_state <= S_FILL_WR;
                S_FILL_WR: begin
                    if (9'(r_x) + 9'd1 >= eff_n) begin
                        r_x <= '0;
                        if (r_lvl == LW'(tal_pkg::LEVELS - 2)) r_state <= S_DONE;
                        else begin r_lvl <= r_lvl + LW'(1); r_state <= S_FILL_RD; end
                    end else begin r_x <= r_x + NW'(1); r_state <= S_FILL_RD; end
                end
                // Climb by set bits of r_k
                S_CL_RD: begin
                    if (r_k == '0) begin
                        if (r_lca) begin
                            if (r_x == r_q) begin
                                r_res <= AW'(r_x); r_state <= S_DONE;
                            end else begin
                                r_lvl <= LW'(tal_pkg::LEVELS - 1); r_state <= S_LC_RA;
                            end
                        end else begin
                            r_res <= AW'(r_x); r_state <= S_DONE;
                        end
                    end else if (k_bit >= 4'(tal_pkg::LEVELS)) r_state <= S_DONE;
                    else r_state <= S_CL_W;
                end
                S_CL_W: r_state <= S_CL_NX;
                S_CL_NX: begin
                    if (anc_rd[NW]) r_state <= S_DONE;
                    else begin
                        r_x <= anc_rd[NW-1:0];
                        r_k[k_bit[2:0]] <= 1'b0;
                        r_state <= S_CL_RD;
                    end
                end
                // LCA: fetch depths, put deeper node in r_x for the climb
                S_LC_DP: r_state <= S_LC_DW;
                S_LC_DW: begin r_dp <= dep_rd; r_state <= S_LC_DQ; end
                S_LC_DQ: r_state <= S_LC_DQW;
                S_LC_DQW: begin
                    r_lca <= 1'b1;
                    if (r_dp > dep_rd) begin
                        r_k <= r_dp - dep_rd;          // climb p, compare with q
                    end else begin
                        r_k <= dep_rd - r_dp;
                        r_x <= r_q; r_q <= r_x;
                    end
                    r_state <= S_CL_RD;
                end
                // Descend levels from the top
                S_LC_RA: r_state <= S_LC_WA;
                S_LC_WA: begin r_tmp <= anc_rd; r_state <= S_LC_RB; end
                S_LC_RB: r_state <= S_LC_WB;
                S_LC_WB: r_state <= S_LC_CMP;
                S_LC_CMP: begin
                    if (r_tmp != anc_rd && (r_tmp[NW] || anc_rd[NW])) begin
                        r_state <= S_DONE;
                    end else begin
                        if (r_tmp != anc_rd) begin
                            r_x <= r_tmp[NW-1:0]; r_q <= anc_rd[NW-1:0];
                        end
                        if (r_lvl == '0) r_state <= S_LC_LAST;
                        else begin r_lvl <= r_lvl - LW'(1); r_state <= S_LC_RA; end
                    end
                end
                S_LC_LAST: r_state <= S_LC_LW;
                S_LC_LW: begin r_res <= anc_rd; r_state <= S_DONE; end
                S_DONE: begin
                    if (!r_valid) begin
                        r_valid <= 1'b1;
                        o_result_node  <= r_res[NW] ? 8'd0 : r_res[7:0];
                        o_result_valid <= !r_res[NW];
                        o_status       <= r_st;
                    end else if (i_ready) begin
                        r_valid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid = r_valid;
endmodule
